>>> rtl/core/contracted_gaussian_orbital_eval_defines.svh
// Assertion macros shared by the orbital evaluator RTL.
`ifndef CONTRACTED_GAUSSIAN_ORBITAL_EVAL_DEFINES_SVH
`define CONTRACTED_GAUSSIAN_ORBITAL_EVAL_DEFINES_SVH

// Clocked check, muted while reset is high.
`define CGO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define CGO_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/cgo_pkg.sv
// Types and fixed coefficients of the contracted Gaussian orbital evaluator.
package cgo_pkg;

  localparam int COEF_W = 32;
  localparam int R2_W   = 32;
  localparam int E_W    = 33;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic        [16:0] orbital_value;
    logic signed [23:0] grad_x;
    logic signed [23:0] grad_y;
    logic signed [23:0] grad_z;
    logic signed [23:0] lap_value;
  } out_item_t;

  // Q.24 coefficients, rounded to nearest
  localparam logic [COEF_W-1:0] A1 = COEF_W'((64'd636242139 * 64'd16777216
                                     + 64'd50000000) / 64'd100000000);
  localparam logic [COEF_W-1:0] A2 = COEF_W'((64'd1158923 * 64'd16777216
                                     + 64'd500000) / 64'd1000000);
  localparam logic [COEF_W-1:0] A3 = COEF_W'((64'd31364979 * 64'd16777216
                                     + 64'd50000000) / 64'd100000000);
  localparam logic [COEF_W-1:0] C1 = COEF_W'((64'd440630314098 * 64'd16777216
                                     + 64'd500000000000) / 64'd1000000000000);
  localparam logic [COEF_W-1:0] C2 = COEF_W'((64'd426158447617 * 64'd16777216
                                     + 64'd500000000000) / 64'd1000000000000);
  localparam logic [COEF_W-1:0] C3 = COEF_W'((64'd132814973358 * 64'd16777216
                                     + 64'd500000000000) / 64'd1000000000000);
  localparam logic [COEF_W-1:0] D1 = COEF_W'((64'd560695147100 * 64'd16777216
                                     + 64'd50000000000) / 64'd100000000000);
  localparam logic [COEF_W-1:0] D2 = COEF_W'((64'd98776965318 * 64'd16777216
                                     + 64'd50000000000) / 64'd100000000000);
  localparam logic [COEF_W-1:0] D3 = COEF_W'((64'd83314777005 * 64'd16777216
                                     + 64'd500000000000) / 64'd1000000000000);
  localparam logic [COEF_W-1:0] L1 = COEF_W'((64'd713475759436 * 64'd16777216
                                     + 64'd5000000000) / 64'd10000000000);
  localparam logic [COEF_W-1:0] L2 = COEF_W'((64'd228949793953 * 64'd16777216
                                     + 64'd50000000000) / 64'd100000000000);
  localparam logic [COEF_W-1:0] L3 = COEF_W'((64'd52263324623 * 64'd16777216
                                     + 64'd500000000000) / 64'd1000000000000);
  localparam logic [COEF_W-1:0] K1 = COEF_W'((64'd168208544130 * 64'd16777216
                                     + 64'd5000000000) / 64'd10000000000);
  localparam logic [COEF_W-1:0] K2 = COEF_W'((64'd296330895953 * 64'd16777216
                                     + 64'd50000000000) / 64'd100000000000);
  localparam logic [COEF_W-1:0] K3 = COEF_W'((64'd249944331015 * 64'd16777216
                                     + 64'd500000000000) / 64'd1000000000000);

endpackage

>>> rtl/core/contracted_gaussian_orbital_eval.sv
// Top level: contracted Gaussian 1s orbital value, gradient and Laplacian pipeline.
//
//   channel  | signals                       | payload
//   ---------+-------------------------------+------------------------------
//   input    | in_valid / in_ready           | in_data  (pos_x, pos_y, pos_z)
//   output   | out_valid / out_ready         | out_data (value, grad, lap)
//
// One transfer per cycle in and out unless a result waits unaccepted; 11 register
// stages (squares, sum, five exp stages, four combine stages) lie between an input
// transfer and its result on out_data.
// All stages advance together; while a result waits unaccepted the whole
// pipeline holds and in_ready drops, so nothing is lost or repeated.
// rst (synchronous) clears only the valid bits; the exp table is a constant.
`include "contracted_gaussian_orbital_eval_defines.svh"

module contracted_gaussian_orbital_eval import cgo_pkg::*; #(
  parameter int EXP_TABLE_ENTRIES = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int PIPE_D = 11;
  localparam logic [E_W-1:0] E_ONE = {1'b1, 32'd0};

  localparam logic [COEF_W-1:0] C_COEF [3] = '{C1, C2, C3};
  localparam logic [COEF_W-1:0] D_COEF [3] = '{D1, D2, D3};
  localparam logic [COEF_W-1:0] L_COEF [3] = '{L1, L2, L3};
  localparam logic [COEF_W-1:0] K_COEF [3] = '{K1, K2, K3};

  // round half away from zero
  function automatic logic signed [67:0] rnd_shift(input logic signed [67:0] v,
                                                   input int sh);
    logic [67:0] mag;
    logic [67:0] r;
    mag = v[67] ? 68'(-v) : 68'(v);
    r   = (mag + (68'd1 << (sh - 1))) >> sh;
    return v[67] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [67:0] v);
    logic signed [23:0] r;
    if (v > 68'sd8388607) r = 24'sh7FFFFF;
    else if (v < -68'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  logic                    en;
  logic [PIPE_D-1:0]       v;

  logic signed [31:0]      mx;
  logic signed [31:0]      my;
  logic signed [31:0]      mz;
  logic [30:0]             sq_x;
  logic [30:0]             sq_y;
  logic [30:0]             sq_z;
  logic [R2_W-1:0]         r2;
  logic [R2_W-1:0]         r2_d [5];
  in_item_t                pos_d [9];

  logic [E_W-1:0]          e_s7 [3];

  logic [63:0]             cv [3];
  logic [63:0]             dv [3];
  logic [63:0]             lr [3];
  logic [24:0]             e24 [3];

  logic [63:0]             vsum;
  logic [63:0]             dsum;
  logic [63:0]             lr_rnd [3];
  logic [16:0]             val9;
  logic [35:0]             sg9;
  logic signed [40:0]      p9 [3];
  logic [24:0]             e24_9 [3];

  logic [16:0]             val10;
  logic signed [52:0]      gp [3];
  logic signed [66:0]      lp [3];
  logic signed [15:0]      crd9 [3];

  logic signed [67:0]      lap_sum;
  out_item_t               out_r;

  // advance everything unless a finished result is waiting
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = v[PIPE_D-1];
  assign out_data  = out_r;

  always_comb begin
    mx = in_data.pos_x * in_data.pos_x;
    my = in_data.pos_y * in_data.pos_y;
    mz = in_data.pos_z * in_data.pos_z;
    vsum = cv[0] + cv[1] + cv[2] + (64'd1 << 39);
    dsum = dv[0] + dv[1] + dv[2] + (64'd1 << 23);
    for (int i = 0; i < 3; i++) begin
      lr_rnd[i] = lr[i] + (64'd1 << 23);
    end
    crd9[0] = pos_d[8].pos_x;
    crd9[1] = pos_d[8].pos_y;
    crd9[2] = pos_d[8].pos_z;
    lap_sum = rnd_shift(68'(lp[0]), 32) + rnd_shift(68'(lp[1]), 32)
            + rnd_shift(68'(lp[2]), 32);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[PIPE_D-2:0], in_valid};
    end
  end

  // three exponentials share r2 from stage 2
  cgo_exp #(.A_COEF(A1), .N_ENTRIES(EXP_TABLE_ENTRIES)) u_exp1 (
    .clk(clk), .en(en), .r2(r2), .e(e_s7[0])
  );
  cgo_exp #(.A_COEF(A2), .N_ENTRIES(EXP_TABLE_ENTRIES)) u_exp2 (
    .clk(clk), .en(en), .r2(r2), .e(e_s7[1])
  );
  cgo_exp #(.A_COEF(A3), .N_ENTRIES(EXP_TABLE_ENTRIES)) u_exp3 (
    .clk(clk), .en(en), .r2(r2), .e(e_s7[2])
  );

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: squares; stage 2: r2 (Q8.24, exact)
      sq_x <= mx[30:0];
      sq_y <= my[30:0];
      sq_z <= mz[30:0];
      r2   <= R2_W'(sq_x) + R2_W'(sq_y) + R2_W'(sq_z);

      // delay lines that keep r2 and the coordinates aligned with their item
      r2_d[0] <= r2;
      for (int i = 1; i < 5; i++) r2_d[i] <= r2_d[i-1];
      pos_d[0] <= in_data;
      for (int i = 1; i < 9; i++) pos_d[i] <= pos_d[i-1];

      // stage 8: coefficient products
      for (int i = 0; i < 3; i++) begin
        cv[i]  <= {32'd0, C_COEF[i]} * 64'(e_s7[i]);
        dv[i]  <= {32'd0, D_COEF[i]} * 64'(e_s7[i]);
        lr[i]  <= {32'd0, L_COEF[i]} * {32'd0, r2_d[4]};
        e24[i] <= 25'((34'(e_s7[i]) + 34'd128) >> 8);
      end

      // stage 9: value, gradient scale, Laplacian polynomial
      val9 <= (vsum[63:40] > 24'd65536) ? 17'd65536 : vsum[56:40];
      sg9  <= dsum[59:24];
      for (int i = 0; i < 3; i++) begin
        p9[i]    <= $signed({1'b0, lr_rnd[i][63:24]}) - $signed({9'd0, K_COEF[i]});
        e24_9[i] <= e24[i];
      end

      // stage 10: coordinate and exponential products
      val10 <= val9;
      for (int i = 0; i < 3; i++) begin
        gp[i] <= 53'(crd9[i]) * 53'($signed({1'b0, sg9}));
        lp[i] <= 67'(p9[i]) * 67'($signed({1'b0, e24_9[i]}));
      end

      // stage 11: round, saturate, drive the output register
      out_r.orbital_value <= val10;
      out_r.grad_x        <= sat24(-rnd_shift(68'(gp[0]), 28));
      out_r.grad_y        <= sat24(-rnd_shift(68'(gp[1]), 28));
      out_r.grad_z        <= sat24(-rnd_shift(68'(gp[2]), 28));
      out_r.lap_value     <= sat24(lap_sum);
    end
  end

  `CGO_ASSERT(a_value_bound, out_valid |-> out_data.orbital_value <= 17'd65536, "value over 1.0")
  `CGO_ASSERT(a_exp_bound, v[6] |-> (e_s7[0] <= E_ONE) && (e_s7[1] <= E_ONE), "exp over 1.0")
  `CGO_ASSERT(a_stall_hold, !in_ready |=> $stable(v), "valid bits moved during stall")
  `CGO_ASSERT_RST(a_reset_empty, $past(rst) |-> v == '0, "pipeline not empty after reset")

endmodule

>>> rtl/core/cgo_exp.sv
// Five-stage exp(-a*r2) unit: scale, table index, table read, interpolate.
module cgo_exp import cgo_pkg::*; #(
  parameter logic [COEF_W-1:0] A_COEF    = '0,
  parameter int                N_ENTRIES = 256
) (
  input  logic             clk,
  input  logic             en,
  input  logic [R2_W-1:0]  r2,
  output logic [E_W-1:0]   e
);

  localparam int IDX_W = $clog2(N_ENTRIES + 1);
  localparam int P_W   = 36 + IDX_W;
  localparam logic [63:0] X_STEP = (64'd1 << 36) / N_ENTRIES;

  typedef logic [E_W-1:0] rom_t [N_ENTRIES+1];

  function automatic rom_t build_rom();
    logic [63:0] t;
    logic [63:0] s;
    rom_t        r;
    int          k;
    t = 64'd1 << 32;
    s = t;
    t = ((t * X_STEP) >> 32) / 64'd1;  s = s - t;
    t = ((t * X_STEP) >> 32) / 64'd2;  s = s + t;
    t = ((t * X_STEP) >> 32) / 64'd3;  s = s - t;
    t = ((t * X_STEP) >> 32) / 64'd4;  s = s + t;
    t = ((t * X_STEP) >> 32) / 64'd5;  s = s - t;
    t = ((t * X_STEP) >> 32) / 64'd6;  s = s + t;
    t = ((t * X_STEP) >> 32) / 64'd7;  s = s - t;
    t = ((t * X_STEP) >> 32) / 64'd8;  s = s + t;
    t = ((t * X_STEP) >> 32) / 64'd9;  s = s - t;
    t = ((t * X_STEP) >> 32) / 64'd10; s = s + t;
    t = ((t * X_STEP) >> 32) / 64'd11; s = s - t;
    t = ((t * X_STEP) >> 32) / 64'd12; s = s + t;
    t = ((t * X_STEP) >> 32) / 64'd13; s = s - t;
    t = ((t * X_STEP) >> 32) / 64'd14; s = s + t;
    t = ((t * X_STEP) >> 32) / 64'd15; s = s - t;
    t = ((t * X_STEP) >> 32) / 64'd16; s = s + t;
    t = ((t * X_STEP) >> 32) / 64'd17; s = s - t;
    t = ((t * X_STEP) >> 32) / 64'd18; s = s + t;
    t = ((t * X_STEP) >> 32) / 64'd19; s = s - t;
    t = ((t * X_STEP) >> 32) / 64'd20; s = s + t;
    t = ((t * X_STEP) >> 32) / 64'd21; s = s - t;
    t = ((t * X_STEP) >> 32) / 64'd22; s = s + t;
    t = ((t * X_STEP) >> 32) / 64'd23; s = s - t;
    t = ((t * X_STEP) >> 32) / 64'd24; s = s + t;
    r[0] = {1'b1, 32'd0};
    for (k = 1; k <= N_ENTRIES; k++) begin
      r[k] = E_W'(({31'd0, r[k-1]} * s + 64'h8000_0000) >> 32);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [63:0]      prod3;
  logic [64:0]      u_sum;
  logic [48:0]      u;
  logic [P_W-1:0]   p;
  logic [IDX_W-1:0] k4;
  logic [IDX_W-1:0] k4_plus;
  logic [31:0]      f4;
  logic             flush4;
  logic [E_W-1:0]   hi5;
  logic [E_W-1:0]   diff5;
  logic [31:0]      f5;
  logic             flush5;
  logic [64:0]      m6;
  logic [E_W-1:0]   hi6;
  logic             flush6;
  logic [E_W-1:0]   e_next;

  always_comb begin
    u_sum   = {1'b0, prod3} + 65'h8000;
    u       = u_sum[64:16];
    p       = P_W'(u[35:0]) * P_W'(N_ENTRIES);
    k4_plus = k4 + IDX_W'(1);
    e_next  = flush6 ? '0 : hi6 - m6[64:32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod3  <= {32'd0, A_COEF} * {32'd0, r2};
      k4     <= p[P_W-1:36];
      f4     <= p[35:4];
      flush4 <= |u[48:36];
      hi5    <= ROM[k4];
      diff5  <= ROM[k4] - ROM[k4_plus];
      f5     <= f4;
      flush5 <= flush4;
      m6     <= 65'(diff5) * 65'(f5);
      hi6    <= hi5;
      flush6 <= flush5;
      e      <= e_next;
    end
  end

endmodule
